FILE: rtl/dhtt_pkg.sv
// dhtt_pkg: shared types and constants for the deadline hash task table
// used by dhtt_ctrl, dhtt_dp, deadline_hash_task_table and dhtt_chk
`timescale 1ns / 1ps

package dhtt_pkg;

  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int BUCKET_DEPTH_DEF = 8;
  localparam int CFG_W            = 5;
  localparam int DL_W             = 16;
  localparam int ID_W             = 8;
  localparam int OUT_SLOT_W       = 4;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 5'd16;
  localparam logic [31:0] GOLDEN_FRAC = 32'h9E37_79B9;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_TFULL = 3'd2,
    ST_BFULL = 3'd3,
    ST_NOTF  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_FOUND = 2'd1,
    SLOT_EMPTY = 2'd2
  } slot_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_PRB_RD,
    S_PRB_CMP,
    S_DECIDE,
    S_SCN_RD,
    S_SCN_CMP,
    S_APPEND,
    S_NEW,
    S_DUP,
    S_BFULL,
    S_TFULL,
    S_NOTF,
    S_EMT_RD,
    S_EMT_OUT
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      hash1;
    logic      hash2;
    logic      prb_chk;
    logic      idx_clr;
    logic      idx_inc;
    logic      out_load;
    status_t   out_status;
    slot_sel_t out_slot_sel;
    logic      out_task;
    logic      append;
    logic      insert;
    logic      pop_clr;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    prb_hit;
    logic    prb_end;
    logic    found;
    logic    has_empty;
    logic    task_hit;
    logic    idx_last;
    logic    bucket_full;
    logic    out_free;
  } sts_t;

endpackage

FILE: rtl/deadline_hash_task_table.sv
// deadline_hash_task_table: top level, joins dhtt_ctrl and dhtt_dp
// depends on dhtt_pkg, dhtt_ctrl, dhtt_dp
//
//   channel | ports                                          | dir
//   cfg     | cfg_valid cfg_ready cfg_table_size             | in
//   in      | in_valid in_ready in_action in_deadline in_task_id | in
//   out     | out_valid out_ready out_status out_task_id_out out_slot out_last | out
//
// one item at a time: hash (HASH1, HASH2), then probe slot by slot (up to n,
// the configured table size), then scan ids for push or emit ids for pop/peek;
// a none action returns to idle after HASH1
// slot counts clear at reset, no clearing pass
// a stalled output holds the sequencer in the state that loads the result
`timescale 1ns / 1ps

module deadline_hash_task_table #(
  parameter int TABLE_DEPTH  = dhtt_pkg::TABLE_DEPTH_DEF,
  parameter int BUCKET_DEPTH = dhtt_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dhtt_pkg::CFG_W-1:0]       cfg_table_size,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic [dhtt_pkg::DL_W-1:0]        in_deadline,
  input  logic [dhtt_pkg::ID_W-1:0]        in_task_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [dhtt_pkg::ID_W-1:0]        out_task_id_out,
  output logic [dhtt_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic                             out_last
);

  dhtt_pkg::cmd_t cmd;
  dhtt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dhtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dhtt_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_table_size  (cfg_table_size),
    .in_action       (in_action),
    .in_deadline     (in_deadline),
    .in_task_id      (in_task_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_task_id_out (out_task_id_out),
    .out_slot        (out_slot),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: rtl/dhtt_ctrl.sv
// dhtt_ctrl: sequencer for hashing, probing, bucket scan and result emission
// depends on dhtt_pkg, drives dhtt_dp through cmd_t and reads sts_t
`timescale 1ns / 1ps

module dhtt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dhtt_pkg::sts_t sts,
  output dhtt_pkg::cmd_t cmd
);

  dhtt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhtt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_status = dhtt_pkg::ST_OK;
    cmd.out_slot_sel = dhtt_pkg::SLOT_NONE;
    in_ready = 1'b0;
    case (state_r)
      dhtt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = dhtt_pkg::S_HASH1;
        end
      end
      dhtt_pkg::S_HASH1: begin
        cmd.hash1 = 1'b1;
        if (sts.act == dhtt_pkg::ACT_NONE) begin
          state_nxt = dhtt_pkg::S_IDLE;
        end else begin
          state_nxt = dhtt_pkg::S_HASH2;
        end
      end
      dhtt_pkg::S_HASH2: begin
        cmd.hash2 = 1'b1;
        state_nxt = dhtt_pkg::S_PRB_RD;
      end
      dhtt_pkg::S_PRB_RD: begin
        state_nxt = dhtt_pkg::S_PRB_CMP;
      end
      dhtt_pkg::S_PRB_CMP: begin
        cmd.prb_chk = 1'b1;
        if (sts.prb_hit || sts.prb_end) begin
          state_nxt = dhtt_pkg::S_DECIDE;
        end else begin
          state_nxt = dhtt_pkg::S_PRB_RD;
        end
      end
      dhtt_pkg::S_DECIDE: begin
        cmd.idx_clr = 1'b1;
        if (sts.act == dhtt_pkg::ACT_PUSH) begin
          if (sts.found) begin
            state_nxt = dhtt_pkg::S_SCN_RD;
          end else if (sts.has_empty) begin
            state_nxt = dhtt_pkg::S_NEW;
          end else begin
            state_nxt = dhtt_pkg::S_TFULL;
          end
        end else begin
          if (sts.found) begin
            state_nxt = dhtt_pkg::S_EMT_RD;
          end else begin
            state_nxt = dhtt_pkg::S_NOTF;
          end
        end
      end
      dhtt_pkg::S_SCN_RD: begin
        state_nxt = dhtt_pkg::S_SCN_CMP;
      end
      dhtt_pkg::S_SCN_CMP: begin
        if (sts.task_hit) begin
          state_nxt = dhtt_pkg::S_DUP;
        end else if (sts.idx_last) begin
          if (sts.bucket_full) begin
            state_nxt = dhtt_pkg::S_BFULL;
          end else begin
            state_nxt = dhtt_pkg::S_APPEND;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = dhtt_pkg::S_SCN_RD;
        end
      end
      dhtt_pkg::S_APPEND: begin
        cmd.out_slot_sel = dhtt_pkg::SLOT_FOUND;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.append = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_NEW: begin
        cmd.out_slot_sel = dhtt_pkg::SLOT_EMPTY;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.insert = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_DUP: begin
        cmd.out_status = dhtt_pkg::ST_DUP;
        cmd.out_slot_sel = dhtt_pkg::SLOT_FOUND;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_BFULL: begin
        cmd.out_status = dhtt_pkg::ST_BFULL;
        cmd.out_slot_sel = dhtt_pkg::SLOT_FOUND;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_TFULL: begin
        cmd.out_status = dhtt_pkg::ST_TFULL;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_NOTF: begin
        cmd.out_status = dhtt_pkg::ST_NOTF;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = dhtt_pkg::S_IDLE;
        end
      end
      dhtt_pkg::S_EMT_RD: begin
        state_nxt = dhtt_pkg::S_EMT_OUT;
      end
      dhtt_pkg::S_EMT_OUT: begin
        cmd.out_slot_sel = dhtt_pkg::SLOT_FOUND;
        cmd.out_task = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.idx_last) begin
            cmd.pop_clr = (sts.act == dhtt_pkg::ACT_POP);
            state_nxt = dhtt_pkg::S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt = dhtt_pkg::S_EMT_RD;
          end
        end
      end
      default: begin
        state_nxt = dhtt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dhtt_dp.sv
// dhtt_dp: hash unit, slot store, task memory and result register
// depends on dhtt_pkg, controlled by dhtt_ctrl
`timescale 1ns / 1ps

module dhtt_dp #(
  parameter int TABLE_DEPTH  = dhtt_pkg::TABLE_DEPTH_DEF,
  parameter int BUCKET_DEPTH = dhtt_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [dhtt_pkg::CFG_W-1:0]       cfg_table_size,
  input  logic [1:0]                       in_action,
  input  logic [dhtt_pkg::DL_W-1:0]        in_deadline,
  input  logic [dhtt_pkg::ID_W-1:0]        in_task_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [dhtt_pkg::ID_W-1:0]        out_task_id_out,
  output logic [dhtt_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic                             out_last,
  input  dhtt_pkg::cmd_t                   cmd,
  output dhtt_pkg::sts_t                   sts
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CW = $clog2(BUCKET_DEPTH + 1);
  localparam int TASK_DEPTH = TABLE_DEPTH * (2 ** BW);

  logic [dhtt_pkg::CFG_W-1:0] tsize_r;
  dhtt_pkg::action_t          act_r;
  logic [dhtt_pkg::DL_W-1:0]  dl_r;
  logic [dhtt_pkg::ID_W-1:0]  id_r;
  logic [31:0]                frac_r;
  logic [NW-1:0]              n_r;
  logic [SW-1:0]              k_r;
  logic [NW-1:0]              pcnt_r;
  logic                       found_r;
  logic [SW-1:0]              fslot_r;
  logic                       empty_r;
  logic [SW-1:0]              eslot_r;
  logic [CW-1:0]              idx_r;
  logic [CW-1:0]              cnt_r [TABLE_DEPTH];
  logic [dhtt_pkg::DL_W-1:0]  dl_mem [TABLE_DEPTH];
  logic [dhtt_pkg::ID_W-1:0]  task_mem [TASK_DEPTH];
  logic [dhtt_pkg::DL_W-1:0]  dl_q_r;
  logic [dhtt_pkg::ID_W-1:0]  td_q_r;

  logic                       out_valid_r;
  logic [2:0]                 out_status_r;
  logic [dhtt_pkg::ID_W-1:0]  out_task_r;
  logic [dhtt_pkg::OUT_SLOT_W-1:0] out_slot_r;
  logic                       out_last_r;

  logic [47:0]                frac_prod;
  logic [NW-1:0]              n_nxt;
  logic [32+NW-1:0]           home_prod;
  logic [SW:0]                k_inc;
  logic [NW:0]                pcnt_inc;
  logic [CW-1:0]              cnt_k;
  logic [CW-1:0]              fcnt;
  logic [CW:0]                idx_inc;
  logic                       prb_hit;
  logic [SW-1:0]              out_slot_idx;

  assign frac_prod = {32'd0, dl_r} * {16'd0, dhtt_pkg::GOLDEN_FRAC};
  assign home_prod = (32 + NW)'(frac_r) * (32 + NW)'(n_r);
  assign k_inc     = {1'b0, k_r} + (SW + 1)'(1);
  assign pcnt_inc  = {1'b0, pcnt_r} + (NW + 1)'(1);
  assign cnt_k     = cnt_r[k_r];
  assign fcnt      = cnt_r[fslot_r];
  assign idx_inc   = {1'b0, idx_r} + (CW + 1)'(1);
  assign prb_hit   = (cnt_k != '0) && (dl_q_r == dl_r);

  always_comb begin
    if (tsize_r == '0) begin
      n_nxt = NW'(1);
    end else if (32'(tsize_r) > 32'(TABLE_DEPTH)) begin
      n_nxt = NW'(TABLE_DEPTH);
    end else begin
      n_nxt = NW'(tsize_r);
    end
  end

  always_comb begin
    case (cmd.out_slot_sel)
      dhtt_pkg::SLOT_FOUND: out_slot_idx = fslot_r;
      dhtt_pkg::SLOT_EMPTY: out_slot_idx = eslot_r;
      default:              out_slot_idx = '0;
    endcase
  end

  always_comb begin
    sts.act         = act_r;
    sts.prb_hit     = prb_hit;
    sts.prb_end     = (pcnt_inc == (NW + 1)'(n_r));
    sts.found       = found_r;
    sts.has_empty   = empty_r;
    sts.task_hit    = (td_q_r == id_r);
    sts.idx_last    = (idx_inc == {1'b0, fcnt});
    sts.bucket_full = (fcnt >= CW'(BUCKET_DEPTH));
    sts.out_free    = !out_valid_r || out_ready;
  end

  // config and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= dhtt_pkg::TABLE_SIZE_RST;
      out_valid_r <= 1'b0;
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tsize_r <= cfg_table_size;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.hash2) begin
        found_r <= 1'b0;
        empty_r <= 1'b0;
      end else if (cmd.prb_chk) begin
        if (prb_hit) begin
          found_r <= 1'b1;
        end
        if (cnt_k == '0 && !empty_r) begin
          empty_r <= 1'b1;
        end
      end
    end
  end

  // slot occupancy counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.append) begin
        cnt_r[fslot_r] <= CW'(fcnt + CW'(1));
      end else if (cmd.insert) begin
        cnt_r[eslot_r] <= CW'(1);
      end else if (cmd.pop_clr) begin
        cnt_r[fslot_r] <= '0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= dhtt_pkg::action_t'(in_action);
      dl_r  <= in_deadline;
      id_r  <= in_task_id;
    end
    if (cmd.hash1) begin
      frac_r <= frac_prod[31:0];
      n_r    <= n_nxt;
    end
    if (cmd.hash2) begin
      k_r    <= SW'(home_prod >> 32);
      pcnt_r <= '0;
    end else if (cmd.prb_chk) begin
      if (prb_hit) begin
        fslot_r <= k_r;
      end
      if (cnt_k == '0 && !empty_r) begin
        eslot_r <= k_r;
      end
      k_r    <= (k_inc == (SW + 1)'(n_r)) ? '0 : k_r + SW'(1);
      pcnt_r <= NW'(pcnt_inc);
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= CW'(idx_inc);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_task_r   <= cmd.out_task ? td_q_r : '0;
      out_slot_r   <= dhtt_pkg::OUT_SLOT_W'(out_slot_idx);
      out_last_r   <= cmd.out_task ? sts.idx_last : 1'b1;
    end
  end

  // deadline and task memories
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      dl_mem[eslot_r] <= dl_r;
    end
    dl_q_r <= dl_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      task_mem[{fslot_r, fcnt[BW-1:0]}] <= id_r;
    end else if (cmd.insert) begin
      task_mem[{eslot_r, BW'(0)}] <= id_r;
    end
    td_q_r <= task_mem[{fslot_r, idx_r[BW-1:0]}];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id_out = out_task_r;
  assign out_slot        = out_slot_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/dhtt_chk.sv
// dhtt_chk: port level checks for deadline_hash_task_table
// depends on dhtt_pkg, bound to the top level below
`timescale 1ns / 1ps

module dhtt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_task_id_out,
  input logic [3:0] out_slot,
  input logic       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_task_id_out) && $stable(out_slot) && $stable(out_last))
    else $error("result changed while stalled");

  // error results stand alone
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dhtt_pkg::ST_OK |-> out_last)
    else $error("error result not last");

  a_err_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dhtt_pkg::ST_OK |-> out_task_id_out == '0)
    else $error("error result carries a task id");

  a_notf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dhtt_pkg::ST_NOTF |-> out_slot == '0)
    else $error("not found result carries a slot");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind deadline_hash_task_table dhtt_chk u_dhtt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_task_id_out (out_task_id_out),
  .out_slot        (out_slot),
  .out_last        (out_last)
);
